>>> hw/rtl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared types and constants of the pointer gesture classifier: event and
// result words, gesture codes, event kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package pgc_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned POS_W      = 16;
	localparam int unsigned BTN_W      = 3;
	localparam int unsigned DELAY_W    = 16;
	localparam int unsigned SHIFT_PX_W = 10;
	localparam int unsigned LIMIT_SQ_W = 2 * SHIFT_PX_W;
	localparam int unsigned DIFF_W     = POS_W + 1;
	localparam int unsigned SQ_W       = 2 * POS_W;
	localparam int unsigned DIST_SQ_W  = SQ_W + 1;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = DELAY_W;

	localparam logic [DELAY_W-1:0]    CLICK_DELAY_RST  = DELAY_W'(500);
	localparam logic [DELAY_W-1:0]    DOUBLE_DELAY_RST = DELAY_W'(200);
	localparam logic [SHIFT_PX_W-1:0] SHIFT_PX_RST     = SHIFT_PX_W'(10);
	localparam logic [LIMIT_SQ_W-1:0] LIMIT_SQ_RST     = LIMIT_SQ_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_CLICK_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_PX     = 2'd2;

	localparam logic [1:0] OP_BUTTON = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_WHEEL  = 2'd2;

	localparam logic [BTN_W-1:0] BTN_NONE = '0;

	typedef enum logic [1:0] {
		GEST_INACTIVE = 2'd0,
		GEST_CLICK    = 2'd1,
		GEST_DOUBLE   = 2'd2,
		GEST_DRAG     = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [1:0]              op;
		logic [TIME_W-1:0]       time_ms;
		logic                    is_release;
		logic [BTN_W-1:0]        button_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] wheel_dx;
		logic signed [POS_W-1:0] wheel_dy;
	} event_t;

	typedef struct packed {
		gesture_t                gesture;
		logic [BTN_W-1:0]        active_button;
		logic signed [POS_W-1:0] cur_x;
		logic signed [POS_W-1:0] cur_y;
		logic signed [POS_W-1:0] prev_x;
		logic signed [POS_W-1:0] prev_y;
		logic signed [POS_W-1:0] press_x;
		logic signed [POS_W-1:0] press_y;
		logic signed [POS_W-1:0] wheel_out_dx;
		logic signed [POS_W-1:0] wheel_out_dy;
	} result_t;

	typedef struct packed {
		logic [DELAY_W-1:0]    click_delay;
		logic [DELAY_W-1:0]    double_delay;
		logic [LIMIT_SQ_W-1:0] limit_sq;
	} cfg_t;

endpackage

>>> hw/rtl/pgc_stream_if.sv
// ----------------------------------------------------------------------------
// pgc_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface pgc_stream_if #(
	parameter type word_t = logic
) ();

	logic  valid;
	logic  ready;
	word_t data;

	modport source (
		output valid,
		output data,
		input  ready
	);

	modport sink (
		input  valid,
		input  data,
		output ready
	);

endinterface

>>> hw/rtl/pgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pgc_cfg_regs
// Configuration registers with a registered square of the shift limit.
// ----------------------------------------------------------------------------
module pgc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pgc_pkg::CFG_IDX_W-1:0]  index,
	input  logic [pgc_pkg::CFG_DATA_W-1:0] wdata,
	output pgc_pkg::cfg_t                  cfg
);
	import pgc_pkg::*;

	logic [DELAY_W-1:0]    click_delay_q;
	logic [DELAY_W-1:0]    double_delay_q;
	logic [SHIFT_PX_W-1:0] shift_px_q;
	logic [LIMIT_SQ_W-1:0] limit_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_delay_q  <= CLICK_DELAY_RST;
			double_delay_q <= DOUBLE_DELAY_RST;
			shift_px_q     <= SHIFT_PX_RST;
			limit_sq_q     <= LIMIT_SQ_RST;
		end else begin
			if (wr_en) begin
				case (index)
					REG_CLICK_DELAY: begin
						click_delay_q <= wdata[DELAY_W-1:0];
					end
					REG_DOUBLE_DELAY: begin
						double_delay_q <= wdata[DELAY_W-1:0];
					end
					REG_SHIFT_PX: begin
						shift_px_q <= wdata[SHIFT_PX_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// squared limit is registered from the stored shift limit, not from wdata
			limit_sq_q <= LIMIT_SQ_W'(shift_px_q * shift_px_q);
		end
	end

	assign cfg.click_delay  = click_delay_q;
	assign cfg.double_delay = double_delay_q;
	assign cfg.limit_sq     = limit_sq_q;

endmodule

>>> hw/rtl/pgc_core.sv
// ----------------------------------------------------------------------------
// pgc_core
// Gesture state registers and the next-state logic for one event word.
// ----------------------------------------------------------------------------
module pgc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  pgc_pkg::event_t  evt,
	input  pgc_pkg::cfg_t    cfg,
	output pgc_pkg::result_t res_next
);
	import pgc_pkg::*;

	gesture_t                gesture_q, gesture_d;
	logic [BTN_W-1:0]        held_q, held_d;
	logic signed [POS_W-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
	logic signed [POS_W-1:0] press_x_q, press_y_q, press_x_d, press_y_d;
	logic [TIME_W-1:0]       press_stamp_q, press_stamp_d;
	logic                    pending_q, pending_d;
	logic [TIME_W-1:0]       click_stamp_q, click_stamp_d;
	logic                    click_seen_q, click_seen_d;
	logic [DIST_SQ_W-1:0]    dist_sq_q, dist_sq_d;
	logic signed [POS_W-1:0] wheel_dx_q, wheel_dy_q, wheel_dx_d, wheel_dy_d;

	logic signed [DIFF_W-1:0]   diff_x, diff_y;
	logic signed [2*DIFF_W-1:0] sq_x, sq_y;
	logic [DIST_SQ_W-1:0]       move_dist_sq;
	logic [DIST_SQ_W-1:0]       limit_sq_ext;
	logic [TIME_W-1:0]          since_click, since_press;
	gesture_t                   gesture_base;
	logic [BTN_W-1:0]           held_base;

	// squared distance from the press point
	assign diff_x       = DIFF_W'(evt.pos_x) - DIFF_W'(press_x_q);
	assign diff_y       = DIFF_W'(evt.pos_y) - DIFF_W'(press_y_q);
	assign sq_x         = diff_x * diff_x;
	assign sq_y         = diff_y * diff_y;
	assign move_dist_sq = {1'b0, sq_x[SQ_W-1:0]} + {1'b0, sq_y[SQ_W-1:0]};
	assign limit_sq_ext = DIST_SQ_W'(cfg.limit_sq);
	assign since_click  = evt.time_ms - click_stamp_q;
	assign since_press  = evt.time_ms - press_stamp_q;

	always_comb begin
		// click states last one event
		if (gesture_q == GEST_CLICK || gesture_q == GEST_DOUBLE) begin
			gesture_base = GEST_INACTIVE;
			held_base    = BTN_NONE;
		end else begin
			gesture_base = gesture_q;
			held_base    = held_q;
		end

		gesture_d     = gesture_base;
		held_d        = held_base;
		cur_x_d       = cur_x_q;
		cur_y_d       = cur_y_q;
		press_x_d     = press_x_q;
		press_y_d     = press_y_q;
		press_stamp_d = press_stamp_q;
		pending_d     = pending_q;
		click_stamp_d = click_stamp_q;
		click_seen_d  = click_seen_q;
		dist_sq_d     = dist_sq_q;
		wheel_dx_d    = wheel_dx_q;
		wheel_dy_d    = wheel_dy_q;

		case (evt.op)
			OP_BUTTON: begin
				if (!evt.is_release) begin
					if (!pending_q) begin
						press_x_d     = cur_x_q;
						press_y_d     = cur_y_q;
						press_stamp_d = evt.time_ms;
						pending_d     = 1'b1;
						held_d        = evt.button_id;
					end
				end else begin
					if (gesture_base == GEST_DRAG) begin
						gesture_d = GEST_INACTIVE;
						held_d    = BTN_NONE;
					end else if (click_seen_q &&
							since_click < TIME_W'(cfg.double_delay)) begin
						gesture_d     = GEST_DOUBLE;
						click_stamp_d = evt.time_ms;
					end else if (pending_q &&
							since_press < TIME_W'(cfg.click_delay) &&
							dist_sq_q < limit_sq_ext) begin
						gesture_d     = GEST_CLICK;
						click_stamp_d = evt.time_ms;
						click_seen_d  = 1'b1;
					end else begin
						held_d = BTN_NONE;
					end
					pending_d = 1'b0;
				end
				dist_sq_d = '0;
			end
			OP_MOVE: begin
				cur_x_d = evt.pos_x;
				cur_y_d = evt.pos_y;
				if (held_base != BTN_NONE) begin
					dist_sq_d = move_dist_sq;
				end
				if (dist_sq_d > limit_sq_ext && gesture_base == GEST_INACTIVE &&
						held_base != BTN_NONE) begin
					gesture_d = GEST_DRAG;
				end
			end
			OP_WHEEL: begin
				wheel_dx_d = evt.wheel_dx;
				wheel_dy_d = evt.wheel_dy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gesture_q     <= GEST_INACTIVE;
			held_q        <= BTN_NONE;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			press_x_q     <= '0;
			press_y_q     <= '0;
			press_stamp_q <= '0;
			pending_q     <= 1'b0;
			click_stamp_q <= '0;
			click_seen_q  <= 1'b0;
			dist_sq_q     <= '0;
			wheel_dx_q    <= '0;
			wheel_dy_q    <= '0;
		end else if (go) begin
			gesture_q     <= gesture_d;
			held_q        <= held_d;
			cur_x_q       <= cur_x_d;
			cur_y_q       <= cur_y_d;
			press_x_q     <= press_x_d;
			press_y_q     <= press_y_d;
			press_stamp_q <= press_stamp_d;
			pending_q     <= pending_d;
			click_stamp_q <= click_stamp_d;
			click_seen_q  <= click_seen_d;
			dist_sq_q     <= dist_sq_d;
			wheel_dx_q    <= wheel_dx_d;
			wheel_dy_q    <= wheel_dy_d;
		end
	end

	assign res_next.gesture       = gesture_d;
	assign res_next.active_button = held_d;
	assign res_next.cur_x         = cur_x_d;
	assign res_next.cur_y         = cur_y_d;
	// position before this word is the stored current position
	assign res_next.prev_x        = cur_x_q;
	assign res_next.prev_y        = cur_y_q;
	assign res_next.press_x       = press_x_d;
	assign res_next.press_y       = press_y_d;
	assign res_next.wheel_out_dx  = wheel_dx_d;
	assign res_next.wheel_out_dy  = wheel_dy_d;

endmodule

>>> hw/rtl/pointer_gesture_classifier.sv
// ----------------------------------------------------------------------------
// pointer_gesture_classifier
// Each event word is registered in the input register, then its result word
// in the result register.
// Throughput: one event word per cycle while results are accepted, set by the
// single pass from input register through gesture logic into result register.
// Reset clears the gesture state and positions to zero and loads the
// configuration defaults.
// ----------------------------------------------------------------------------
module pointer_gesture_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	pgc_stream_if.sink                     evt,
	pgc_stream_if.source                   res,
	input  logic                           cfg_wr_en,
	input  logic [pgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pgc_pkg::*;

	cfg_t    cfg;
	event_t  evt_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    go;
	logic    take;

	assign go        = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || go;
	assign take      = evt.valid && evt.ready;

	pgc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	pgc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.evt      (evt_s1),
		.cfg      (cfg),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !go);
			valid_s2 <= go || (valid_s2 && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1 <= evt.data;
		end
		if (go) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

`ifndef SYNTHESIS
	a_go_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> valid_s2)
		else $error("result register not loaded");

	a_drag_has_button: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.gesture == GEST_DRAG) |-> res_s2.active_button != BTN_NONE)
		else $error("drag without held button");

	a_move_sets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(go && evt_s1.op == OP_MOVE) |=>
			(res_s2.cur_x == $past(evt_s1.pos_x) && res_s2.cur_y == $past(evt_s1.pos_y)))
		else $error("move word did not update position");
`endif

endmodule
